/* sv/pxacc_pkg.sv */
// ----------------------------------------------------------------------------
// pxacc_pkg
// Shared types and constants of the paxos acceptor slot table.
// ----------------------------------------------------------------------------
`default_nettype none

package pxacc_pkg;

	localparam int SLOT_COUNT  = 1024;
	localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
	localparam int BALLOT_BITS = 32;
	localparam int VALUE_BITS  = 64;

	localparam logic OP_PREPARE = 1'b0;
	localparam logic OP_ACCEPT  = 1'b1;

	localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(SLOT_COUNT - 1);

	// promise store word, cleared at reset
	typedef struct packed {
		logic                   voted;
		logic [BALLOT_BITS-1:0] promise;
	} meta_t;

	// vote store word, never cleared
	typedef struct packed {
		logic [BALLOT_BITS-1:0] ballot;
		logic [VALUE_BITS-1:0]  value;
	} vote_t;

endpackage

`default_nettype wire

/* sv/paxos_acceptor_slot_table_core.sv */
// ----------------------------------------------------------------------------
// paxos_acceptor_slot_table_core
// Multi-paxos acceptor: per-slot promise, vote flag and last accepted vote,
// kept in two synchronous memories with read-modify-write and forwarding.
// ----------------------------------------------------------------------------
// s1 registers the request and store reads; the result register then holds the reply and done
// one request per cycle while busy is low; back-to-back requests to one slot are forwarded
// the receiver cannot stall: each result is shown for exactly one cycle
// after reset, busy stays high while the promise store is swept to zero
// the vote store is not cleared; its data is reported only for slots whose vote flag is set
`default_nettype none

module paxos_acceptor_slot_table_core import pxacc_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	output logic                        busy,
	input  wire logic                   op,
	input  wire logic [SLOT_BITS-1:0]   slot,
	input  wire logic [BALLOT_BITS-1:0] ballot,
	input  wire logic [VALUE_BITS-1:0]  value,
	output logic                        done,
	output logic                        ack,
	output logic [BALLOT_BITS-1:0]      advice_ballot,
	output logic                        has_vote,
	output logic [BALLOT_BITS-1:0]      vote_ballot,
	output logic [VALUE_BITS-1:0]       vote_value
);

	meta_t meta_mem [SLOT_COUNT];
	vote_t vote_mem [SLOT_COUNT];

	logic                 clr_active_q;
	logic [SLOT_BITS-1:0] clr_addr_q;

	logic                   s1_valid_q;
	logic                   s1_op_q;
	logic [SLOT_BITS-1:0]   s1_slot_q;
	logic [BALLOT_BITS-1:0] s1_ballot_q;
	logic [VALUE_BITS-1:0]  s1_value_q;

	meta_t meta_rd_q;
	vote_t vote_rd_q;
	logic  byp_meta_q;
	logic  byp_vote_q;
	meta_t byp_meta_data_q;
	vote_t byp_vote_data_q;

	logic                   done_q;
	logic                   ack_q;
	logic [BALLOT_BITS-1:0] advice_q;
	logic                   has_vote_q;
	logic [BALLOT_BITS-1:0] vote_ballot_q;
	logic [VALUE_BITS-1:0]  vote_value_q;

	logic  take;
	meta_t meta_cur;
	vote_t vote_cur;
	logic  grant;
	logic  meta_we;
	logic  vote_we;
	meta_t meta_wdata;
	vote_t vote_wdata;
	logic  same_slot;

	assign busy = clr_active_q;
	assign take = start && !busy;

	// forwarded data covers the write that lands in the same edge as the read
	assign meta_cur = byp_meta_q ? byp_meta_data_q : meta_rd_q;
	assign vote_cur = byp_vote_q ? byp_vote_data_q : vote_rd_q;

	assign grant   = !(s1_ballot_q < meta_cur.promise);
	assign meta_we = s1_valid_q && grant;
	assign vote_we = s1_valid_q && grant && (s1_op_q == OP_ACCEPT);

	always_comb begin
		meta_wdata.promise = s1_ballot_q;
		meta_wdata.voted   = meta_cur.voted || (s1_op_q == OP_ACCEPT);
		vote_wdata.ballot  = s1_ballot_q;
		vote_wdata.value   = s1_value_q;
	end

	assign same_slot = take && s1_valid_q && (slot == s1_slot_q);

	// clearing sweep of the promise store
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
		end else if (clr_active_q) begin
			clr_addr_q <= clr_addr_q + SLOT_BITS'(1);
			if (clr_addr_q == SLOT_LAST) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clr_active_q) begin
			meta_mem[clr_addr_q] <= '0;
		end else if (meta_we) begin
			meta_mem[s1_slot_q] <= meta_wdata;
		end
		meta_rd_q <= meta_mem[slot];
	end

	always_ff @(posedge clk) begin
		if (vote_we) begin
			vote_mem[s1_slot_q] <= vote_wdata;
		end
		vote_rd_q <= vote_mem[slot];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			byp_meta_q <= 1'b0;
			byp_vote_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			s1_valid_q <= take;
			byp_meta_q <= same_slot && meta_we;
			byp_vote_q <= same_slot && vote_we;
			done_q     <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		s1_op_q         <= op;
		s1_slot_q       <= slot;
		s1_ballot_q     <= ballot;
		s1_value_q      <= value;
		byp_meta_data_q <= meta_wdata;
		byp_vote_data_q <= vote_wdata;
	end

	// result register
	always_ff @(posedge clk) begin
		ack_q         <= grant;
		advice_q      <= grant ? '0 : meta_cur.promise;
		has_vote_q    <= 1'b0;
		vote_ballot_q <= '0;
		vote_value_q  <= '0;
		if (grant && (s1_op_q == OP_PREPARE) && meta_cur.voted) begin
			has_vote_q    <= 1'b1;
			vote_ballot_q <= vote_cur.ballot;
			vote_value_q  <= vote_cur.value;
		end
	end

	assign done          = done_q;
	assign ack           = ack_q;
	assign advice_ballot = advice_q;
	assign has_vote      = has_vote_q;
	assign vote_ballot   = vote_ballot_q;
	assign vote_value    = vote_value_q;

	a_take_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> ##2 done)
		else $error("accepted request produced no result");

	a_no_work_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !s1_valid_q && !done_q)
		else $error("request in flight during clearing sweep");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && !ack |-> !has_vote && vote_ballot == '0 && vote_value == '0)
		else $error("rejection carries vote data");

	a_vote_needs_ack: assert property (@(posedge clk) disable iff (!arst_n)
		done && has_vote |-> ack && advice_ballot == '0)
		else $error("vote reported without grant");

	a_fwd_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		byp_vote_q |-> byp_meta_q && s1_valid_q)
		else $error("vote forward without promise forward");

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the paxos acceptor slot table. A table of directed requests
// covers grants, rejections, ballot equality, the extreme slots and ballots
// and back-to-back requests to one slot; random prepare/accept traffic then
// contends on a few hot slots. Each result is checked field by field against
// the table's expected reply or a local model of the per-slot promise and vote store.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import pxacc_pkg::*;

	localparam int RANDOM_REQUESTS = 850;
	localparam int QUIET_LIMIT     = 5000;
	localparam int NUM_ROWS        = 24;

	typedef struct packed {
		logic                   op;
		logic [SLOT_BITS-1:0]   slot;
		logic [BALLOT_BITS-1:0] ballot;
		logic [VALUE_BITS-1:0]  value;
	} request_t;

	typedef struct packed {
		logic                   ack;
		logic [BALLOT_BITS-1:0] advice_ballot;
		logic                   has_vote;
		logic [BALLOT_BITS-1:0] vote_ballot;
		logic [VALUE_BITS-1:0]  vote_value;
	} reply_t;

	typedef struct packed {
		request_t rq;
		logic     typed;
		reply_t   rp;
	} row_t;

	localparam logic [BALLOT_BITS-1:0] TOP_BALLOT = '1;
	localparam logic [VALUE_BITS-1:0]  ONES       = '1;
	localparam reply_t GRANT_PLAIN = '{1'b1, '0, 1'b0, '0, '0};

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	logic op     = OP_PREPARE;
	logic [SLOT_BITS-1:0]   slot   = '0;
	logic [BALLOT_BITS-1:0] ballot = '0;
	logic [VALUE_BITS-1:0]  value  = '0;

	logic                   busy;
	logic                   done;
	logic                   ack;
	logic [BALLOT_BITS-1:0] advice_ballot;
	logic                   has_vote;
	logic [BALLOT_BITS-1:0] vote_ballot;
	logic [VALUE_BITS-1:0]  vote_value;

	paxos_acceptor_slot_table_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.slot(slot),
		.ballot(ballot),
		.value(value),
		.done(done),
		.ack(ack),
		.advice_ballot(advice_ballot),
		.has_vote(has_vote),
		.vote_ballot(vote_ballot),
		.vote_value(vote_value)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// local copy of the acceptor state
	logic [BALLOT_BITS-1:0] promise_mem     [SLOT_COUNT] = '{default: '0};
	logic                   voted_mem       [SLOT_COUNT] = '{default: 1'b0};
	logic [BALLOT_BITS-1:0] vote_ballot_mem [SLOT_COUNT] = '{default: '0};
	logic [VALUE_BITS-1:0]  vote_value_mem  [SLOT_COUNT] = '{default: '0};

	reply_t replies_due [$];
	int     fail_count = 0;
	int     quiet_cycles = 0;

	logic [SLOT_BITS-1:0] hot_slots [8] = '{10'd0, 10'd1, 10'd2, 10'd3,
		SLOT_LAST, SLOT_LAST - 10'd1, 10'h155, 10'h2aa};

	row_t directed_rows [NUM_ROWS] = '{
		// fresh slot, ballot equal to the zero promise
		'{'{OP_PREPARE, 10'd0, 32'd0, 64'd0}, 1'b1, GRANT_PLAIN},
		'{'{OP_ACCEPT,  10'd0, 32'd0, ONES},  1'b1, GRANT_PLAIN},
		'{'{OP_PREPARE, 10'd0, 32'd0, 64'd0}, 1'b1, '{1'b1, '0, 1'b1, 32'd0, ONES}},
		// top slot, top ballot
		'{'{OP_PREPARE, SLOT_LAST, TOP_BALLOT, ONES}, 1'b1, GRANT_PLAIN},
		'{'{OP_ACCEPT,  SLOT_LAST, 32'hffff_fffe, 64'h5555_5555_5555_5555}, 1'b1,
			'{1'b0, TOP_BALLOT, 1'b0, '0, '0}},
		'{'{OP_PREPARE, SLOT_LAST, 32'd0, 64'd0}, 1'b1, '{1'b0, TOP_BALLOT, 1'b0, '0, '0}},
		'{'{OP_ACCEPT,  SLOT_LAST, TOP_BALLOT, 64'h0123_4567_89ab_cdef}, 1'b1, GRANT_PLAIN},
		'{'{OP_PREPARE, SLOT_LAST, TOP_BALLOT, 64'd0}, 1'b1,
			'{1'b1, '0, 1'b1, TOP_BALLOT, 64'h0123_4567_89ab_cdef}},
		// promise raised by accept, then by prepare
		'{'{OP_ACCEPT,  10'd1, 32'h100, 64'd0}, 1'b1, GRANT_PLAIN},
		'{'{OP_ACCEPT,  10'd1, 32'h0ff, ONES},  1'b1, '{1'b0, 32'h100, 1'b0, '0, '0}},
		'{'{OP_PREPARE, 10'd1, 32'h200, 64'd0}, 1'b1, '{1'b1, '0, 1'b1, 32'h100, 64'd0}},
		'{'{OP_ACCEPT,  10'd1, 32'h180, 64'd0}, 1'b1, '{1'b0, 32'h200, 1'b0, '0, '0}},
		'{'{OP_ACCEPT,  10'd1, 32'h200, 64'haaaa_aaaa_aaaa_aaaa}, 1'b1, GRANT_PLAIN},
		'{'{OP_PREPARE, 10'd1, 32'h200, 64'd0}, 1'b1,
			'{1'b1, '0, 1'b1, 32'h200, 64'haaaa_aaaa_aaaa_aaaa}},
		// back-to-back on one slot exercises forwarding
		'{'{OP_PREPARE, 10'd2, 32'd5, 64'd0}, 1'b0, '0},
		'{'{OP_PREPARE, 10'd2, 32'd3, 64'd0}, 1'b0, '0},
		'{'{OP_ACCEPT,  10'd2, 32'd7, 64'hdead_beef_cafe_f00d}, 1'b0, '0},
		'{'{OP_ACCEPT,  10'd2, 32'd6, 64'd1}, 1'b0, '0},
		'{'{OP_PREPARE, 10'd2, 32'd8, 64'd0}, 1'b0, '0},
		'{'{OP_PREPARE, 10'h200, 32'h8000_0000, 64'd0}, 1'b0, '0},
		'{'{OP_ACCEPT,  10'h200, 32'h7fff_ffff, 64'd0}, 1'b0, '0},
		'{'{OP_ACCEPT,  10'h155, 32'h5555_5555, 64'h5555_5555_5555_5555}, 1'b0, '0},
		'{'{OP_PREPARE, 10'h2aa, 32'haaaa_aaaa, 64'd0}, 1'b0, '0},
		'{'{OP_PREPARE, 10'h155, 32'h5555_5555, 64'd0}, 1'b0, '0}
	};

	function automatic reply_t resolve_request(input request_t rq);
		reply_t rp;
		rp = '0;
		if (rq.ballot < promise_mem[rq.slot]) begin
			rp.advice_ballot = promise_mem[rq.slot];
		end else begin
			rp.ack = 1'b1;
			promise_mem[rq.slot] = rq.ballot;
			if (rq.op == OP_PREPARE) begin
				if (voted_mem[rq.slot]) begin
					rp.has_vote    = 1'b1;
					rp.vote_ballot = vote_ballot_mem[rq.slot];
					rp.vote_value  = vote_value_mem[rq.slot];
				end
			end else begin
				voted_mem[rq.slot]       = 1'b1;
				vote_ballot_mem[rq.slot] = rq.ballot;
				vote_value_mem[rq.slot]  = rq.value;
			end
		end
		return rp;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%0t mismatch: %s", $time, msg);
	endtask

	// holds the request on the ports until an edge with busy low takes it
	task automatic present_request(input request_t rq, input logic typed, input reply_t typed_rp);
		reply_t rp;
		start  <= 1'b1;
		op     <= rq.op;
		slot   <= rq.slot;
		ballot <= rq.ballot;
		value  <= rq.value;
		do
			@(posedge clk);
		while (busy);
		rp = resolve_request(rq);
		replies_due.push_back(typed ? typed_rp : rp);
	endtask

	// start low, other inputs wander
	task automatic idle_cycles(input int n);
		if (n > 0)
			start <= 1'b0;
		repeat (n) begin
			op     <= 1'($urandom);
			slot   <= SLOT_BITS'($urandom);
			ballot <= $urandom;
			value  <= {$urandom, $urandom};
			@(posedge clk);
		end
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	initial begin
		request_t rq;
		int       r;
		int       steady_left;
		steady_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			present_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].rp);

		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			rq.op = 1'($urandom);
			if ($urandom_range(0, 99) < 75)
				rq.slot = hot_slots[$urandom_range(0, 7)];
			else
				rq.slot = SLOT_BITS'($urandom_range(0, SLOT_COUNT - 1));
			// mostly ballots near the current promise so grants and refusals mix
			r = $urandom_range(0, 99);
			if (r < 60)
				rq.ballot = promise_mem[rq.slot] + BALLOT_BITS'($urandom_range(0, 8)) - 3;
			else if (r < 94)
				rq.ballot = $urandom;
			else if (r < 97)
				rq.ballot = TOP_BALLOT;
			else
				rq.ballot = '0;
			rq.value = {$urandom, $urandom};
			present_request(rq, 1'b0, '0);

			if (steady_left > 0)
				steady_left--;
			else if ($urandom_range(0, 49) == 0)
				steady_left = $urandom_range(30, 60);
			else
				idle_cycles(pick_gap());
		end
		start <= 1'b0;

		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	always @(posedge clk) begin
		reply_t want;
		reply_t got;
		if (arst_n && done) begin
			got = '{ack, advice_ballot, has_vote, vote_ballot, vote_value};
			if (replies_due.size() == 0) begin
				note_failure($sformatf("result with no request outstanding: %h", got));
			end else begin
				want = replies_due.pop_front();
				if (got.ack !== want.ack || got.advice_ballot !== want.advice_ballot ||
						got.has_vote !== want.has_vote || got.vote_ballot !== want.vote_ballot ||
						got.vote_value !== want.vote_value)
					note_failure($sformatf(
						"exp ack=%b adv=%h has=%b vb=%h vv=%h / got ack=%b adv=%h has=%b vb=%h vv=%h",
						want.ack, want.advice_ballot, want.has_vote, want.vote_ballot,
						want.vote_value, got.ack, got.advice_ballot, got.has_vote,
						got.vote_ballot, got.vote_value));
			end
		end
	end

	// cycles in which neither a request nor a result moves
	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

endmodule

`default_nettype wire
